[hdl/serial_line_editor_assert.svh]
// Assertion macros shared by the serial line editor.
`ifndef SERIAL_LINE_EDITOR_ASSERT_SVH
`define SERIAL_LINE_EDITOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

    // Line buffer geometry.
    localparam int BUF_DEPTH = 128;
    localparam int PTR_W     = $clog2(BUF_DEPTH);
    localparam logic [PTR_W-1:0] WP_LAST = PTR_W'(BUF_DEPTH - 1);

    // Field widths.
    localparam int REQ_W  = 2;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 7;
    localparam int LEN_W  = 7;

    // Queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_ECHO_ENABLE = 1'b0;

    // Characters the editor recognizes or sends.
    localparam logic [BYTE_W-1:0] CH_NUL = 8'd0;
    localparam logic [BYTE_W-1:0] CH_BS  = 8'd8;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'd32;
    localparam logic [BYTE_W-1:0] CH_DEL = 8'd127;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_BYTE  = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // Echo sequence that a request produces.
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_CHAR = 2'd1,
        KIND_CR   = 2'd2,
        KIND_BS   = 2'd3
    } t_kind;

    // Request as classified by the front, before the buffer read returns.
    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  echo_byte;
        logic [LEN_W-1:0]   len;
        logic               is_read;
        logic               oob;
    } t_job;

    // Queue entry handed to the back part.
    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  echo_byte;
        logic [LEN_W-1:0]   len;
        logic [BYTE_W-1:0]  rdata;
    } t_entry;

endpackage

`default_nettype wire

[hdl/sle_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module sle_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  [sle_pkg::REQ_W-1:0]    i_req_type,
    input  wire  [sle_pkg::BYTE_W-1:0]   i_rx_byte,
    input  wire  [sle_pkg::IDX_W-1:0]    i_read_index,
    input  wire                          i_echo_enable,
    output logic                         o_push,
    output sle_pkg::t_entry              o_entry,
    input  wire                          i_full
);
    import sle_pkg::*;

    logic [BYTE_W-1:0] r_mem [BUF_DEPTH];
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [LEN_W-1:0]  r_cl, n_cl;
    logic              r_s1_valid;
    t_job              r_s1, n_job;
    logic [BYTE_W-1:0] r_rdata;
    logic              accept;
    logic              mem_we;
    logic [BYTE_W-1:0] mem_wdata;
    logic [PTR_W-1:0]  rd_ptr;
    t_req              req;

    // The classified request waits in stage one until the queue takes it.
    assign o_stall = r_s1_valid && i_full;
    assign o_push  = r_s1_valid && !i_full;
    assign accept  = i_valid && !o_stall;
    assign req     = t_req'(i_req_type);
    assign rd_ptr  = PTR_W'(i_read_index);

    // Classify the request and work out the new line state.
    always_comb begin
        n_wp      = r_wp;
        n_cl      = r_cl;
        mem_we    = 1'b0;
        mem_wdata = i_rx_byte;
        n_job.kind      = KIND_NONE;
        n_job.echo_byte = i_rx_byte;
        n_job.is_read   = 1'b0;
        n_job.oob       = 32'(i_read_index) >= BUF_DEPTH;
        case (req)
            REQ_CLEAR: begin
                n_wp = '0;
                n_cl = '0;
            end
            REQ_READ: begin
                n_job.is_read = 1'b1;
            end
            REQ_BYTE: begin
                if (r_cl == '0) begin
                    if (i_rx_byte == CH_BS || i_rx_byte == CH_DEL) begin
                        if (r_wp != '0) begin
                            n_wp = r_wp - 1'b1;
                            if (i_echo_enable) begin
                                n_job.kind = KIND_BS;
                            end
                        end
                    end else if (i_rx_byte == CH_CR) begin
                        mem_we    = 1'b1;
                        mem_wdata = CH_NUL;
                        n_cl      = LEN_W'(32'(r_wp));
                        n_wp      = '0;
                        if (i_echo_enable) begin
                            n_job.kind = KIND_CR;
                        end
                    end else begin
                        mem_we = 1'b1;
                        n_wp   = (r_wp == WP_LAST) ? '0 : r_wp + 1'b1;
                        if (i_echo_enable) begin
                            n_job.kind = KIND_CHAR;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        n_job.len = n_cl;
    end

    // Line state and stage-one control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_cl       <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_wp       <= n_wp;
                r_cl       <= n_cl;
                r_s1_valid <= 1'b1;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Stage-one payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_job;
        end
    end

    // Line buffer: one write and one registered read per cycle, both only on an accepted request.
    always_ff @(posedge i_clk) begin
        if (accept && mem_we) begin
            r_mem[r_wp] <= mem_wdata;
        end
        if (accept) begin
            r_rdata <= r_mem[rd_ptr];
        end
    end

    // Merge the read data into the queue entry.
    always_comb begin
        o_entry.kind      = r_s1.kind;
        o_entry.echo_byte = r_s1.echo_byte;
        o_entry.len       = r_s1.len;
        o_entry.rdata     = (r_s1.is_read && !r_s1.oob) ? r_rdata : '0;
    end

endmodule

`default_nettype wire

[hdl/sle_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module sle_queue (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_push,
    input  sle_pkg::t_entry              i_entry,
    output logic                         o_full,
    output logic                         o_valid,
    output sle_pkg::t_entry              o_head,
    input  wire                          i_pop,
    output logic [sle_pkg::QCNT_W-1:0]   o_count
);
    import sle_pkg::*;

    t_entry              r_slot [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_count;
    logic                do_push, do_pop;

    assign o_full  = r_count == QCNT_W'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_slot[r_rd];
    assign o_count = r_count;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

[hdl/sle_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module sle_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_q_valid,
    input  sle_pkg::t_entry              i_head,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic                         o_echo_valid,
    output logic [sle_pkg::BYTE_W-1:0]   o_echo_byte,
    output logic                         o_line_ready,
    output logic [sle_pkg::LEN_W-1:0]    o_line_length,
    output logic [sle_pkg::BYTE_W-1:0]   o_read_data,
    output logic                         o_last
);
    import sle_pkg::*;

    logic [1:0]        r_step;
    logic              load;
    logic              emit;
    logic              n_ev;
    logic [BYTE_W-1:0] n_eb;
    logic              n_last;

    assign load  = !o_valid || !i_stall;
    assign emit  = load && i_q_valid;
    assign o_pop = emit && n_last;

    // Pick the result for the current step of the echo sequence.
    always_comb begin
        n_ev   = 1'b1;
        n_eb   = CH_NUL;
        n_last = 1'b1;
        case (i_head.kind)
            KIND_CHAR: begin
                n_eb = i_head.echo_byte;
            end
            KIND_CR: begin
                n_eb   = (r_step == 2'd0) ? CH_LF : CH_CR;
                n_last = r_step != 2'd0;
            end
            KIND_BS: begin
                n_eb   = (r_step == 2'd1) ? CH_SP : CH_BS;
                n_last = r_step == 2'd2;
            end
            default: begin
                n_ev = 1'b0;
            end
        endcase
    end

    // Output register and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_step  <= '0;
        end else if (load) begin
            o_valid <= i_q_valid;
            if (emit) begin
                r_step <= n_last ? 2'd0 : r_step + 1'b1;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_echo_valid  <= n_ev;
            o_echo_byte   <= n_eb;
            o_line_ready  <= i_head.len != '0;
            o_line_length <= i_head.len;
            o_read_data   <= i_head.rdata;
            o_last        <= n_last;
        end
    end

endmodule

`default_nettype wire

[hdl/serial_line_editor.sv]
// A request passes through stage one, the queue and the back's output register before its first result appears.
// Throughput: one request per cycle when each gives a single result and the output
// is not stalled; echo sequences give one result per byte (up to three).
// A four-entry queue lets the front keep accepting while results wait.
// Reset is synchronous and active low; it empties the line and echo is off.
`timescale 1ns / 1ps
`default_nettype none

module serial_line_editor (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  [sle_pkg::REQ_W-1:0]    i_req_type,
    input  wire  [sle_pkg::BYTE_W-1:0]   i_rx_byte,
    input  wire  [sle_pkg::IDX_W-1:0]    i_read_index,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic                         o_echo_valid,
    output logic [sle_pkg::BYTE_W-1:0]   o_echo_byte,
    output logic                         o_line_ready,
    output logic [sle_pkg::LEN_W-1:0]    o_line_length,
    output logic [sle_pkg::BYTE_W-1:0]   o_read_data,
    output logic                         o_last,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [sle_pkg::PADDR_W-1:0]  paddr,
    input  wire  [sle_pkg::PDATA_W-1:0]  pwdata,
    output logic [sle_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import sle_pkg::*;

    logic                r_echo_en;
    logic                q_push, q_full, q_valid, q_pop;
    t_entry              q_in, q_head;
    logic [QCNT_W-1:0]   q_count;
    logic                reg_sel;

    // Configuration register.
    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1] == REG_ECHO_ENABLE;
    assign prdata  = reg_sel ? PDATA_W'(r_echo_en) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_en <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_echo_en <= pwdata[0];
        end
    end

    // Front: accepts and classifies requests, owns the line buffer.
    sle_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_rx_byte     (i_rx_byte),
        .i_read_index  (i_read_index),
        .i_echo_enable (r_echo_en),
        .o_push        (q_push),
        .o_entry       (q_in),
        .i_full        (q_full)
    );

    // Queue between the two parts.
    sle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop),
        .o_count (q_count)
    );

    // Back: expands each entry into its results.
    sle_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_head        (q_head),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_echo_valid  (o_echo_valid),
        .o_echo_byte   (o_echo_byte),
        .o_line_ready  (o_line_ready),
        .o_line_length (o_line_length),
        .o_read_data   (o_read_data),
        .o_last        (o_last)
    );

`include "serial_line_editor_assert.svh"

    // The queue never holds more entries than it has slots.
    `SLE_ASSERT_SAME(a_queue_bound, i_clk, i_rst_n, 1'b1, q_count <= QCNT_W'(QDEPTH), "queue overflow")
    // A result without echo always ends its request.
    `SLE_ASSERT_SAME(a_noecho_last, i_clk, i_rst_n, o_valid && !o_echo_valid, o_last, "no-echo result not last")
    // Read data only appears on a single result without echo.
    `SLE_ASSERT_SAME(a_read_alone, i_clk, i_rst_n, o_valid && o_read_data != '0, o_last && !o_echo_valid, "read data on echo result")
    // A full queue with a waiting entry holds off the sender.
    `SLE_ASSERT_NEXT(a_front_hold, i_clk, i_rst_n, o_stall && !q_pop, o_stall, "stall dropped without pop")

endmodule

`default_nettype wire
